### rtl/psup_pkg.sv
// psup_pkg: shared constants and types for the png scanline unpremultiply packer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package psup_pkg;

  localparam int MAX_DIM_DEF = 16384;
  localparam int DIM_W       = 15;
  localparam int PIX_W       = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [PIX_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [PIX_W-1:0] FILTER_NONE  = 8'h00;

  typedef struct packed {
    logic row_start;
    logic img_end;
  } pos_info_t;

  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] color;
    logic [PIX_W-1:0] alpha;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/psup_if.sv
// psup channel interfaces: pixel input, scanline byte output, register writes
// depends on psup_pkg for field widths
`timescale 1ns / 1ps

interface psup_pix_if import psup_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface psup_byte_if import psup_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_byte;
  logic             last;
  logic             image_end;
  modport source (output valid, out_byte, last, image_end, input ready);
  modport sink   (input valid, out_byte, last, image_end, output ready);
endinterface

interface psup_cfg_if import psup_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/psup_div.sv
// psup_div: shared 8-step restoring divider computing min(color, alpha) * 255 / alpha
// depends on psup_pkg
`timescale 1ns / 1ps

module psup_div import psup_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(PIX_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PIX_W-1:0] rem_r, rem_nxt;
  logic [PIX_W-1:0] sh_r, sh_nxt;
  logic [PIX_W-1:0] alpha_r, alpha_nxt;

  logic [PIX_W-1:0]   clamped;
  logic [2*PIX_W-1:0] prod;
  logic [PIX_W:0]     trial;
  logic               fits;

  always_comb begin
    clamped = (req.color > req.alpha) ? req.alpha : req.color;
    // times 255 as shift and subtract
    prod    = {clamped, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, clamped};
    trial   = {rem_r, sh_r[PIX_W-1]};
    fits    = trial >= {1'b0, alpha_r};

    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    alpha_nxt = alpha_r;

    if (req.start) begin
      run_nxt   = 1'b1;
      cnt_nxt   = CNT_W'(PIX_W);
      rem_nxt   = prod[2*PIX_W-1:PIX_W];
      sh_nxt    = prod[PIX_W-1:0];
      alpha_nxt = req.alpha;
    end else if (run_r) begin
      rem_nxt = fits ? PIX_W'(trial - {1'b0, alpha_r}) : trial[PIX_W-1:0];
      sh_nxt  = {sh_r[PIX_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    sh_r    <= sh_nxt;
    alpha_r <= alpha_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = sh_r;

endmodule

### rtl/psup_pos.sv
// psup_pos: column and row counters that mark row starts and the image end
// depends on psup_pkg
`timescale 1ns / 1ps

module psup_pos import psup_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [$clog2(MAX_DIM+1)-1:0] width,
  input  logic [$clog2(MAX_DIM+1)-1:0] height,
  output pos_info_t                    info
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [DW-1:0] ncol, nrow;
  logic          row_wrap, img_wrap;

  always_comb begin
    ncol     = DW'(col_r) + DW'(1);
    nrow     = DW'(row_r) + DW'(1);
    row_wrap = ncol >= width;
    img_wrap = row_wrap && (nrow >= height);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (advance) begin
      col_nxt = row_wrap ? '0 : CW'(ncol);
      if (row_wrap) begin
        row_nxt = img_wrap ? '0 : CW'(nrow);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign info.row_start = col_r == '0;
  assign info.img_end   = img_wrap;

endmodule

### rtl/png_scanline_unpremultiply_packer.sv
// png_scanline_unpremultiply_packer: pixel to png raw scanline byte serializer
// depends on psup_pkg, psup_if, psup_pos and psup_div
`timescale 1ns / 1ps

// Takes one pixel per transfer on in_ch and sends its scanline bytes on out_ch:
// a filter byte 0 at each row start, then R, G, B and, in alpha mode, A. In alpha
// mode colors are clamped to alpha and scaled by 255/alpha unless alpha is 0 or 255.
// The block handles one pixel at a time and is not ready until its last byte has
// been transferred. In alpha mode, when alpha is neither 0 nor 255, one shared
// 8-step restoring divider works on the three color channels in turn.
// Register writes on cfg_ch are always accepted and belong between pixels.
// After the last pixel of an image the counters wrap and a new image begins.

module png_scanline_unpremultiply_packer import psup_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input logic        clk,
  input logic        rst_n,
  psup_pix_if.sink   in_ch,
  psup_byte_if.source out_ch,
  psup_cfg_if.sink   cfg_ch
);

  localparam int DW = $clog2(MAX_DIM + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  localparam logic [2:0] CH_FILT = 3'd0;
  localparam logic [2:0] CH_R    = 3'd1;
  localparam logic [2:0] CH_G    = 3'd2;
  localparam logic [2:0] CH_B    = 3'd3;
  localparam logic [2:0] CH_A    = 3'd4;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       ch_r, ch_nxt;
  logic [PIX_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic             end_r, end_nxt;
  logic [PIX_W-1:0] obyte_r, obyte_nxt;
  logic             olast_r, olast_nxt;
  logic             oend_r, oend_nxt;

  logic [DW-1:0] width_r, height_r;
  logic          has_alpha_r;
  logic [DW-1:0] dim_eff;

  logic             in_xfer;
  logic [PIX_W-1:0] cval;
  pos_info_t        pos;
  div_req_t         dreq;
  div_rsp_t         drsp;

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg_ch.data == '0) begin
      dim_eff = DW'(1);
    end else if (32'(cfg_ch.data) > 32'(MAX_DIM)) begin
      dim_eff = DW'(MAX_DIM);
    end else begin
      dim_eff = DW'(cfg_ch.data);
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DW'(1);
      height_r    <= DW'(1);
      has_alpha_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WIDTH:  width_r     <= dim_eff;
        REG_HEIGHT: height_r    <= dim_eff;
        REG_ALPHA:  has_alpha_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = state_r == ST_IDLE;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  psup_pos #(.MAX_DIM(MAX_DIM)) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer),
    .width   (width_r),
    .height  (height_r),
    .info    (pos)
  );

  psup_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    case (ch_r)
      CH_R:    cval = red_r;
      CH_G:    cval = green_r;
      default: cval = blue_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    end_nxt    = end_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    oend_nxt   = oend_r;
    dreq.color = cval;
    dreq.alpha = alpha_r;
    dreq.start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ch_nxt    = pos.row_start ? CH_FILT : CH_R;
          end_nxt   = pos.img_end;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        unique case (ch_r) inside
          CH_FILT: begin
            obyte_nxt = FILTER_NONE;
            olast_nxt = 1'b0;
            oend_nxt  = 1'b0;
            state_nxt = ST_SEND;
          end
          CH_A: begin
            obyte_nxt = alpha_r;
            olast_nxt = 1'b1;
            oend_nxt  = end_r;
            state_nxt = ST_SEND;
          end
          CH_R, CH_G, CH_B: begin
            if (has_alpha_r && alpha_r != ALPHA_CLEAR && alpha_r != ALPHA_OPAQUE) begin
              dreq.start = 1'b1;
              state_nxt  = ST_DIV;
            end else begin
              obyte_nxt = cval;
              olast_nxt = !has_alpha_r && (ch_r == CH_B);
              oend_nxt  = !has_alpha_r && (ch_r == CH_B) && end_r;
              state_nxt = ST_SEND;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (drsp.done) begin
          obyte_nxt = drsp.quot;
          olast_nxt = 1'b0;
          oend_nxt  = 1'b0;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_ch.ready) begin
          if (olast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + 3'd1;
            state_nxt = ST_PREP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= CH_FILT;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      end_r   <= end_nxt;
    end
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
    if (in_xfer) begin
      red_r   <= in_ch.red;
      green_r <= in_ch.green;
      blue_r  <= in_ch.blue;
      alpha_r <= in_ch.alpha;
    end
  end

  assign out_ch.valid     = state_r == ST_SEND;
  assign out_ch.out_byte  = obyte_r;
  assign out_ch.last      = olast_r;
  assign out_ch.image_end = oend_r;

endmodule

### sim/png_scanline_unpremultiply_packer_tb.sv
// png_scanline_unpremultiply_packer_tb: self-checking bench for the png scanline packer
// drives pixels and register writes through the psup interfaces, checks every output byte
// against an in-bench predictor; depends on psup_pkg, psup_if and the packer rtl
`timescale 1ns / 1ps

module png_scanline_unpremultiply_packer_tb;
  import psup_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_DIR     = 16;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 56;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
    logic             image_end;
  } sl_byte_t;

  typedef struct packed {
    logic             set_regs;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             alpha_on;
    pixel_t           px;
    logic [2:0]       n_typed;
    logic [39:0]      typed_bytes;
    logic             typed_end;
  } dir_row_t;

  logic clk;
  logic rst_n;

  psup_pix_if  pix ();
  psup_byte_if byt ();
  psup_cfg_if  cfg ();

  png_scanline_unpremultiply_packer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix),
    .out_ch (byt),
    .cfg_ch (cfg)
  );

  // shadow of the block state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             alpha_mode;
  logic [13:0]      col_cnt;
  logic [13:0]      row_cnt;

  sl_byte_t scanline_q[$];
  int       mismatches;
  int       send_gap_pct;
  int       recv_stall_pct;
  bit       hold_req;
  dir_row_t dir_tab [NUM_DIR];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(v);
  endfunction

  function automatic logic [PIX_W-1:0] straight_color(logic [PIX_W-1:0] c, logic [PIX_W-1:0] a);
    int unsigned cc;
    if (a == ALPHA_CLEAR || a == ALPHA_OPAQUE) return c;
    cc = (c > a) ? 32'(a) : 32'(c);
    return PIX_W'((cc * 255) / 32'(a));
  endfunction

  function automatic void push_byte(logic [PIX_W-1:0] v, logic l, logic e);
    sl_byte_t b;
    b.value     = v;
    b.last      = l;
    b.image_end = e;
    scanline_q.push_back(b);
  endfunction

  // advances row/column state; queues the pixel's bytes when keep is set
  function automatic void pack_scanline_bytes(pixel_t px, bit keep);
    int unsigned w;
    int unsigned h;
    int unsigned ncol;
    int unsigned nrow;
    logic        fin;
    w    = eff_dim(width_reg);
    h    = eff_dim(height_reg);
    ncol = col_cnt + 1;
    nrow = row_cnt;
    fin  = 1'b0;
    if (ncol >= w) begin
      ncol = 0;
      nrow = row_cnt + 1;
      if (nrow >= h) begin
        nrow = 0;
        fin  = 1'b1;
      end
    end
    if (keep) begin
      if (col_cnt == 0) push_byte(FILTER_NONE, 1'b0, 1'b0);
      if (alpha_mode) begin
        push_byte(straight_color(px.red, px.alpha), 1'b0, 1'b0);
        push_byte(straight_color(px.green, px.alpha), 1'b0, 1'b0);
        push_byte(straight_color(px.blue, px.alpha), 1'b0, 1'b0);
        push_byte(px.alpha, 1'b1, fin);
      end else begin
        push_byte(px.red, 1'b0, 1'b0);
        push_byte(px.green, 1'b0, 1'b0);
        push_byte(px.blue, 1'b1, fin);
      end
    end
    col_cnt = ncol[13:0];
    row_cnt = nrow[13:0];
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_WIDTH:  width_reg  = val;
      REG_HEIGHT: height_reg = val;
      REG_ALPHA:  alpha_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic apply_setting(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic am);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ALPHA, {{(DIM_W-1){1'b0}}, am});
  endtask

  // sender stops offering until every queued byte has been transferred
  task automatic drain_bytes();
    @(negedge clk);
    pix.valid = 1'b0;
    while (scanline_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t px, logic [2:0] n_typed, logic [39:0] typed_bytes,
                            logic typed_end);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid = 1'b1;
    pix.red   = px.red;
    pix.green = px.green;
    pix.blue  = px.blue;
    pix.alpha = px.alpha;
    do @(posedge clk); while (!pix.ready);
    pack_scanline_bytes(px, n_typed == 0);
    for (int k = 0; k < n_typed; k++)
      push_byte(typed_bytes[39-8*k -: 8], k == n_typed - 1, (k == n_typed - 1) && typed_end);
  endtask

  function automatic pixel_t rand_pixel(logic am);
    pixel_t px;
    int     sel;
    px.red   = PIX_W'($urandom_range(255));
    px.green = PIX_W'($urandom_range(255));
    px.blue  = PIX_W'($urandom_range(255));
    sel      = $urandom_range(7);
    if (!am || sel > 1) px.alpha = PIX_W'($urandom_range(255));
    else px.alpha = (sel == 0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    if (am && sel == 2) px.alpha = PIX_W'($urandom_range(8, 1));
    return px;
  endfunction

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    byt.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        byt.ready = 1'b0;
      end else begin
        byt.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : byte_check
    sl_byte_t want;
    if (rst_n && byt.valid && byt.ready) begin
      if (scanline_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected byte %02h last %b image_end %b", $time,
                   byt.out_byte, byt.last, byt.image_end);
      end else begin
        want = scanline_q.pop_front();
        if (byt.out_byte !== want.value || byt.last !== want.last ||
            byt.image_end !== want.image_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] byte mismatch: expected %02h/%b/%b got %02h/%b/%b", $time,
                     want.value, want.last, want.image_end,
                     byt.out_byte, byt.last, byt.image_end);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pix.valid && pix.ready) || (byt.valid && byt.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("png_scanline_unpremultiply_packer verification failed");
    $finish;
  end

  initial begin
    logic [DIM_W-1:0] ph_w  [NUM_PHASES];
    logic [DIM_W-1:0] ph_h  [NUM_PHASES];
    logic             ph_am [NUM_PHASES];
    dir_row_t         row;

    ph_w  = '{15'd1, 15'd3, 15'h4000, 15'd0, 15'd5, 15'd2, 15'h7fff, 15'd4};
    ph_h  = '{15'd2, 15'd3, 15'd1, 15'd3, 15'h7fff, 15'd0, 15'h4000, 15'd2};
    ph_am = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    // reset setting: one-pixel image, rgb
    dir_tab[0]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'h00_00_00_00, 3'd4, 40'h00_00_00_00_00, 1'b1};
    dir_tab[1]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'hff_ff_ff_5a, 3'd4, 40'h00_ff_ff_ff_00, 1'b1};
    // zero dimensions act as one, alpha mode
    dir_tab[2]  = '{1'b1, 15'd0, 15'd0, 1'b1, 32'h80_40_ff_00, 3'd5, 40'h00_80_40_ff_00, 1'b1};
    dir_tab[3]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'h12_34_56_ff, 3'd5, 40'h00_12_34_56_ff, 1'b1};
    dir_tab[4]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'h40_80_ff_80, 3'd5, 40'h00_7f_ff_ff_80, 1'b1};
    dir_tab[5]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'h00_01_02_01, 3'd0, 40'h0, 1'b0};
    dir_tab[6]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'hfe_fd_01_fe, 3'd0, 40'h0, 1'b0};
    // width grows to four, then shrinks mid-row
    dir_tab[7]  = '{1'b1, 15'd4, 15'd2, 1'b0, 32'ha5_5a_3c_c3, 3'd0, 40'h0, 1'b0};
    dir_tab[8]  = '{1'b0, 15'd0, 15'd0, 1'b0, 32'h01_02_04_08, 3'd0, 40'h0, 1'b0};
    dir_tab[9]  = '{1'b1, 15'd1, 15'd2, 1'b0, 32'h10_20_40_80, 3'd0, 40'h0, 1'b0};
    dir_tab[10] = '{1'b0, 15'd0, 15'd0, 1'b0, 32'h7f_80_fe_01, 3'd0, 40'h0, 1'b0};
    // oversized dimensions clamp
    dir_tab[11] = '{1'b1, 15'h7fff, 15'h7fff, 1'b1, 32'h99_66_33_cc, 3'd0, 40'h0, 1'b0};
    dir_tab[12] = '{1'b0, 15'd0, 15'd0, 1'b0, 32'hc8_c9_ca_c9, 3'd0, 40'h0, 1'b0};
    dir_tab[13] = '{1'b1, 15'h4000, 15'd1, 1'b1, 32'h55_aa_ff_fe, 3'd0, 40'h0, 1'b0};
    dir_tab[14] = '{1'b1, 15'd1, 15'd1, 1'b0, 32'h00_ff_00_ff, 3'd0, 40'h0, 1'b0};
    dir_tab[15] = '{1'b1, 15'd2, 15'd1, 1'b1, 32'h02_03_04_02, 3'd0, 40'h0, 1'b0};

    rst_n          = 1'b0;
    pix.valid      = 1'b0;
    pix.red        = '0;
    pix.green      = '0;
    pix.blue       = '0;
    pix.alpha      = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_WIDTH;
    cfg.data       = '0;
    width_reg      = 15'd1;
    height_reg     = 15'd1;
    alpha_mode     = 1'b0;
    col_cnt        = '0;
    row_cnt        = '0;
    mismatches     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_tab[i];
      if (row.set_regs) begin
        drain_bytes();
        apply_setting(row.width, row.height, row.alpha_on);
      end
      send_pixel(row.px, row.n_typed, row.typed_bytes, row.typed_end);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_bytes();
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
        default: begin send_gap_pct = 29; recv_stall_pct = 29; end
      endcase
      apply_setting(ph_w[p], ph_h[p], ph_am[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering pixels
        if (p == 0 && n == 5) hold_req = 1'b1;
        if (p == 5 && n == 28) drain_bytes();
        send_pixel(rand_pixel(alpha_mode), 3'd0, 40'h0, 1'b0);
      end
    end

    drain_bytes();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && scanline_q.size() == 0)
      $display("png_scanline_unpremultiply_packer verification clean");
    else
      $display("png_scanline_unpremultiply_packer verification failed");
    $finish;
  end

endmodule

### png_scanline_unpremultiply_packer.f
rtl/psup_pkg.sv
rtl/psup_if.sv
rtl/psup_div.sv
rtl/psup_pos.sv
rtl/png_scanline_unpremultiply_packer.sv
sim/png_scanline_unpremultiply_packer_tb.sv
